// ===== hdl/div64_pkg.sv =====
`timescale 1ns / 1ps

package div64_pkg;

  localparam int FIELD_W          = 64;
  localparam int OP_W             = 2;
  localparam int DATA_WIDTH_DEF   = 64;

  localparam logic [OP_W-1:0] OP_UQUO = 2'd0;
  localparam logic [OP_W-1:0] OP_UREM = 2'd1;
  localparam logic [OP_W-1:0] OP_SQUO = 2'd2;
  localparam logic [OP_W-1:0] OP_SREM = 2'd3;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } div64_cmd_t;

endpackage

// ===== hdl/div64_req_if.sv =====
`timescale 1ns / 1ps

interface div64_req_if import div64_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [FIELD_W-1:0] dividend;
  logic [FIELD_W-1:0] divisor;

  modport source (output valid, op, dividend, divisor, input ready);
  modport sink (input valid, op, dividend, divisor, output ready);
endinterface

// ===== hdl/div64_rsp_if.sv =====
`timescale 1ns / 1ps

interface div64_rsp_if import div64_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] result;
  logic               divide_by_zero;

  modport source (output valid, result, divide_by_zero, input ready);
  modport sink (input valid, result, divide_by_zero, output ready);
endinterface

// ===== hdl/divider_64bit_signed_unsigned_top.sv =====
`timescale 1ns / 1ps
// Integer divider: unsigned/signed quotient and remainder, DATA_WIDTH bits.
// Request channel (req): op, dividend, divisor; taken on valid && ready.
// Response channel (rsp): result, divide_by_zero; taken on valid && ready.
// op: 0 unsigned quotient, 1 unsigned remainder, 2 signed quotient,
// 3 signed remainder. Signed quotients truncate toward zero; the most
// negative value divided by -1 wraps. Division by zero returns the fixed
// values (1, 0, +1/-1 by dividend sign, dividend) and raises divide_by_zero.
// Operand bits above DATA_WIDTH are ignored; result bits above it are zero.
// Sequence: operand magnitudes load on the accepting edge, then DATA_WIDTH
// restoring shift-subtract steps run, then one sign-fix step registers the
// result. One request is in work at a time: req.ready is high only while
// the controller is idle, so the next request is taken only after the
// sign-fix step, and the single shared subtract unit sets the pace.
// A finished response sits in an output register; the next request is taken
// meanwhile. If the receiver stalls, the following result waits in the
// sign-fix step until the output register frees.
// Reset (synchronous rst) empties the controller and the output register.

module divider_64bit_signed_unsigned_top import div64_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  div64_req_if.sink   req,
  div64_rsp_if.source rsp
);

  div64_cmd_t cmd;

  div64_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  div64_dp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .op             (req.op),
    .dividend       (req.dividend),
    .divisor        (req.divisor),
    .result         (rsp.result),
    .divide_by_zero (rsp.divide_by_zero)
  );

endmodule

// ===== hdl/div64_ctrl.sv =====
`timescale 1ns / 1ps

module div64_ctrl import div64_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output div64_cmd_t cmd
);

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_WIDTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             out_valid;
  logic             out_valid_next;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_valid;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          count_next = '0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (count == LAST) begin
          state_next = S_FIX;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      S_FIX: begin
        if (!out_valid || rsp_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    out_valid_next = cmd.finish | (out_valid & ~rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hdl/div64_dp.sv =====
`timescale 1ns / 1ps

module div64_dp import div64_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  div64_cmd_t         cmd,
  input  logic [OP_W-1:0]    op,
  input  logic [FIELD_W-1:0] dividend,
  input  logic [FIELD_W-1:0] divisor,
  output logic [FIELD_W-1:0] result,
  output logic               divide_by_zero
);

  localparam int W = DATA_WIDTH;

  logic [OP_W-1:0] op_r;
  logic            nneg;
  logic            dneg;
  logic            zero;
  logic [W-1:0]    quo;
  logic [W-1:0]    rem;
  logic [W-1:0]    den;
  logic [W-1:0]    res;
  logic            dbz;

  logic [W-1:0]    n_in;
  logic [W-1:0]    d_in;
  logic            signed_op;
  logic            n_sign;
  logic            d_sign;
  logic [W:0]      rem_sh;
  logic [W+1:0]    diff;
  logic            ge;
  logic [W-1:0]    mag;
  logic            neg;
  logic [W-1:0]    res_next;

  assign n_in      = dividend[W-1:0];
  assign d_in      = divisor[W-1:0];
  assign signed_op = op[1];
  assign n_sign    = signed_op & n_in[W-1];
  assign d_sign    = signed_op & d_in[W-1];

  assign rem_sh = {rem, quo[W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};
  assign ge     = ~diff[W+1];

  always_comb begin
    if (op_r[0]) begin
      mag = rem;
    end else if (zero) begin
      mag = W'(1);
    end else begin
      mag = quo;
    end
    neg = op_r[1] & (op_r[0] ? nneg : (nneg ^ dneg));
    if (op_r == OP_UREM && zero) begin
      res_next = '0;
    end else if (neg) begin
      res_next = ~mag + W'(1);
    end else begin
      res_next = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op;
      nneg <= n_sign;
      dneg <= d_sign;
      zero <= (d_in == '0);
      quo  <= n_sign ? (~n_in + W'(1)) : n_in;
      den  <= d_sign ? (~d_in + W'(1)) : d_in;
      rem  <= '0;
    end else if (cmd.step) begin
      quo <= {quo[W-2:0], ge};
      rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
    end
    if (cmd.finish) begin
      res <= res_next;
      dbz <= zero;
    end
  end

  assign result         = FIELD_W'(res);
  assign divide_by_zero = dbz;

endmodule
